// ===== design/blvs_pkg.sv =====
`timescale 1ns / 1ps

package blvs_pkg;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_BACK   = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;
	localparam logic [2:0] CMD_DELETE     = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_UP,
		CM_DOWN,
		CM_LOAD,
		CM_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       at_len;
		logic       at_tail;
	} cell_ctl_t;

endpackage

// ===== design/blvs_cell.sv =====
`timescale 1ns / 1ps

module blvs_cell #(
	parameter int W = 32
) (
	input  logic                clk,
	input  blvs_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]        fill,
	input  logic [W-1:0]        prev,
	input  logic [W-1:0]        next,
	input  logic [W-1:0]        front,
	output logic [W-1:0]        q
);

	always_ff @(posedge clk) begin
		case (ctl.mode)
			blvs_pkg::CM_HOLD: q <= q;
			blvs_pkg::CM_UP: q <= prev;
			blvs_pkg::CM_DOWN: q <= next;
			blvs_pkg::CM_LOAD: begin
				if (ctl.at_len) begin
					q <= fill;
				end
			end
			blvs_pkg::CM_ROTATE: q <= ctl.at_tail ? front : next;
			default: q <= q;
		endcase
	end

endmodule

// ===== design/bounded_list_with_value_search.sv =====
// Push, pop and unused commands: the result is registered and appears in the cycle after the request,
// and a new request may follow in the very next cycle.
// Search and delete rotate the whole list once through the cell chain, one entry
// per cycle: busy stays high through the rotation and the final result, so no new request is accepted meanwhile.
// Search matches come out during the rotation, the last one after it; results never stall.
// Reset clears the entry count and the control state; entry contents are not reset.
`timescale 1ns / 1ps

module bounded_list_with_value_search #(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               result_valid,
	output logic [1:0]         status,
	output logic [3:0]         position,
	output logic [4:0]         entry_count,
	output logic               last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = VALUE_WIDTH;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   occ_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   step_q;
	logic [CW-1:0]   pend_pos_q;
	logic            pend_q;
	logic            hit_q;
	logic            is_del_q;
	logic [VW-1:0]   val_q;
	logic [VW-1:0]   val_in;
	logic [VW-1:0]   cq [DEPTH];
	logic [VW-1:0]   prv [DEPTH];
	logic [VW-1:0]   nxt [DEPTH];
	blvs_pkg::cell_mode_t mode;
	blvs_pkg::cell_ctl_t  ctl [DEPTH];
	logic            accept;
	logic            full;
	logic            empty;
	logic            match;

	generate
		if (VW <= 32) begin : g_narrow
			assign val_in = value[VW-1:0];
		end else begin : g_wide
			assign val_in = {{(VW - 32){1'b0}}, value};
		end
	endgenerate

	assign accept = start && !busy;
	assign full   = (occ_q == CW'(DEPTH));
	assign empty  = (occ_q == '0);
	assign match  = (cq[0] == val_q);

	always_comb begin
		mode = blvs_pkg::CM_HOLD;
		if (state_q == S_SCAN) begin
			mode = blvs_pkg::CM_ROTATE;
		end else if (state_q == S_IDLE && accept) begin
			case (command)
				blvs_pkg::CMD_PUSH_FRONT: mode = full ? blvs_pkg::CM_HOLD : blvs_pkg::CM_UP;
				blvs_pkg::CMD_PUSH_BACK: mode = full ? blvs_pkg::CM_HOLD : blvs_pkg::CM_LOAD;
				blvs_pkg::CMD_POP_FRONT: mode = empty ? blvs_pkg::CM_HOLD : blvs_pkg::CM_DOWN;
				default: mode = blvs_pkg::CM_HOLD;
			endcase
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign prv[i] = val_in;
			end else begin : g_mid
				assign prv[i] = cq[i-1];
			end
			if (i == DEPTH - 1) begin : g_end
				assign nxt[i] = cq[i];
			end else begin : g_inner
				assign nxt[i] = cq[i+1];
			end
			assign ctl[i].mode    = mode;
			assign ctl[i].at_len  = (occ_q == CW'(i));
			assign ctl[i].at_tail = (occ_q == CW'(i + 1));

			blvs_cell #(
				.W(VW)
			) u_cell (
				.clk  (clk),
				.ctl  (ctl[i]),
				.fill (val_in),
				.prev (prv[i]),
				.next (nxt[i]),
				.front(cq[0]),
				.q    (cq[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			busy         <= 1'b0;
			occ_q        <= '0;
			n_q          <= '0;
			step_q       <= '0;
			pend_pos_q   <= '0;
			pend_q       <= 1'b0;
			hit_q        <= 1'b0;
			is_del_q     <= 1'b0;
			val_q        <= '0;
			result_valid <= 1'b0;
			status       <= blvs_pkg::ST_OK;
			position     <= '0;
			entry_count  <= '0;
			last         <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q      <= val_in;
						n_q        <= occ_q;
						step_q     <= '0;
						pend_q     <= 1'b0;
						hit_q      <= 1'b0;
						is_del_q   <= (command == blvs_pkg::CMD_DELETE);
						position   <= '0;
						last       <= 1'b1;
						status     <= blvs_pkg::ST_OK;
						entry_count <= 5'(occ_q);
						case (command)
							blvs_pkg::CMD_PUSH_FRONT, blvs_pkg::CMD_PUSH_BACK: begin
								result_valid <= 1'b1;
								if (full) begin
									status <= blvs_pkg::ST_FULL;
								end else begin
									occ_q       <= occ_q + 1'b1;
									entry_count <= 5'(occ_q + 1'b1);
								end
							end
							blvs_pkg::CMD_POP_BACK, blvs_pkg::CMD_POP_FRONT: begin
								result_valid <= 1'b1;
								if (empty) begin
									status <= blvs_pkg::ST_EMPTY;
								end else begin
									occ_q       <= occ_q - 1'b1;
									entry_count <= 5'(occ_q - 1'b1);
								end
							end
							blvs_pkg::CMD_SEARCH, blvs_pkg::CMD_DELETE: begin
								if (empty) begin
									result_valid <= 1'b1;
									status       <= blvs_pkg::ST_NOT_FOUND;
								end else begin
									busy    <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							default: result_valid <= 1'b1;
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
						if (is_del_q) begin
							occ_q <= occ_q - 1'b1;
						end else begin
							pend_q     <= 1'b1;
							pend_pos_q <= step_q;
							if (pend_q) begin
								result_valid <= 1'b1;
								status       <= blvs_pkg::ST_OK;
								position     <= 4'(pend_pos_q);
								entry_count  <= 5'(occ_q);
								last         <= 1'b0;
							end
						end
					end
					step_q <= step_q + 1'b1;
					if (step_q == n_q - 1'b1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					result_valid <= 1'b1;
					last         <= 1'b1;
					entry_count  <= 5'(occ_q);
					status       <= hit_q ? blvs_pkg::ST_OK : blvs_pkg::ST_NOT_FOUND;
					position     <= (hit_q && !is_del_q) ? 4'(pend_pos_q) : 4'd0;
					busy         <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: begin
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy && state_q != S_IDLE && !is_del_q)
		else $error("intermediate result outside a search");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == blvs_pkg::ST_FULL |-> entry_count == 5'(DEPTH))
		else $error("full reported with room left");

	a_scan_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && !is_del_q |=> $stable(occ_q))
		else $error("search changed the entry count");

endmodule

// ===== tb/sv/tb_bounded_list_with_value_search.sv =====
`timescale 1ns / 1ps

module tb_bounded_list_with_value_search;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] position;
		logic [4:0] count;
		logic       last;
	} list_result_t;

	class list_tracker;
		logic [31:0]  contents[$];
		list_result_t awaited[$];
		int           failures;
		int           requests;
		int           checked;
		int           multi_hit_searches;
		int           refused_pushes;
		int           peak;

		function void add_result(logic [1:0] st, logic [3:0] pos, logic fin);
			list_result_t item;
			item.status   = st;
			item.position = pos;
			item.count    = 5'(contents.size());
			item.last     = fin;
			awaited = {awaited, item};
		endfunction

		function void note_request(logic [2:0] cmd, logic [31:0] key);
			logic [31:0]  kept[$];
			list_result_t hits[$];
			list_result_t item;
			requests++;
			case (cmd)
				blvs_pkg::CMD_PUSH_FRONT, blvs_pkg::CMD_PUSH_BACK: begin
					if (contents.size() >= DEPTH) begin
						refused_pushes++;
						add_result(blvs_pkg::ST_FULL, 4'd0, 1'b1);
					end else begin
						if (cmd == blvs_pkg::CMD_PUSH_FRONT)
							contents = {key, contents};
						else
							contents = {contents, key};
						add_result(blvs_pkg::ST_OK, 4'd0, 1'b1);
					end
				end
				blvs_pkg::CMD_POP_BACK, blvs_pkg::CMD_POP_FRONT: begin
					if (contents.size() == 0) begin
						add_result(blvs_pkg::ST_EMPTY, 4'd0, 1'b1);
					end else begin
						if (cmd == blvs_pkg::CMD_POP_BACK)
							contents.delete(contents.size() - 1);
						else
							contents.delete(0);
						add_result(blvs_pkg::ST_OK, 4'd0, 1'b1);
					end
				end
				blvs_pkg::CMD_SEARCH: begin
					for (int i = 0; i < contents.size(); i++) begin
						if (contents[i] == key) begin
							item.status   = blvs_pkg::ST_OK;
							item.position = 4'(i);
							item.count    = 5'(contents.size());
							item.last     = 1'b0;
							hits = {hits, item};
						end
					end
					if (hits.size() == 0) begin
						add_result(blvs_pkg::ST_NOT_FOUND, 4'd0, 1'b1);
					end else begin
						if (hits.size() > 1)
							multi_hit_searches++;
						hits[hits.size() - 1].last = 1'b1;
						foreach (hits[i])
							awaited = {awaited, hits[i]};
					end
				end
				blvs_pkg::CMD_DELETE: begin
					foreach (contents[i])
						if (contents[i] != key)
							kept = {kept, contents[i]};
					if (kept.size() == contents.size()) begin
						add_result(blvs_pkg::ST_NOT_FOUND, 4'd0, 1'b1);
					end else begin
						contents = kept;
						add_result(blvs_pkg::ST_OK, 4'd0, 1'b1);
					end
				end
				default: begin
					add_result(blvs_pkg::ST_OK, 4'd0, 1'b1);
				end
			endcase
			if (contents.size() > peak)
				peak = contents.size();
		endfunction

		function void check_result(logic [1:0] st, logic [3:0] pos, logic [4:0] cnt, logic fin);
			list_result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: status %0d position %0d entry_count %0d last %0d",
					st, pos, cnt, fin);
				failures++;
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			checked++;
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				failures++;
			end
			if (pos !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, pos);
				failures++;
			end
			if (cnt !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, cnt);
				failures++;
			end
			if (fin !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, fin);
				failures++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         command;
	logic signed [31:0] value;
	logic               result_valid;
	logic [1:0]         status;
	logic [3:0]         position;
	logic [4:0]         entry_count;
	logic               last;

	list_tracker tracker;

	bounded_list_with_value_search #(
		.DEPTH(DEPTH),
		.VALUE_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.value(value),
		.result_valid(result_valid),
		.status(status),
		.position(position),
		.entry_count(entry_count),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			tracker.check_result(status, position, entry_count, last);
	end

	task automatic issue(input logic [2:0] cmd, input logic [31:0] key, input int gap);
		repeat (gap) begin
			@(negedge clk);
			start   <= 1'b0;
			command <= 3'($urandom);
			value   <= $urandom;
		end
		@(negedge clk);
		start   <= 1'b1;
		command <= cmd;
		value   <= key;
		do
			@(posedge clk);
		while (busy);
		tracker.note_request(cmd, key);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] pool[4];
		pool[0] = 32'h8000_0000;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'h7FFF_FFFF;
		if ($urandom_range(0, 99) < 70)
			return pool[$urandom_range(0, 3)];
		return $urandom;
	endfunction

	initial begin
		#1ms;
		$display("bounded_list_with_value_search: mismatch");
		$finish;
	end

	initial begin
		logic [2:0] cmd;
		int         r;
		int         gap;
		int         spins;
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		command = blvs_pkg::CMD_PUSH_FRONT;
		value   = 32'sd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty list, unused codes, extremes of the value and duplicate matches.
		issue(blvs_pkg::CMD_POP_BACK, 32'h0, 0);
		issue(blvs_pkg::CMD_POP_FRONT, 32'h0, 1);
		issue(blvs_pkg::CMD_SEARCH, 32'h0, 0);
		issue(blvs_pkg::CMD_DELETE, 32'h0, 0);
		issue(3'd6, 32'hFFFF_FFFF, 0);
		issue(3'd7, 32'h0, 2);
		issue(blvs_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF, 0);
		issue(blvs_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 0);
		issue(blvs_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 0);
		issue(blvs_pkg::CMD_PUSH_BACK, 32'h8000_0000, 0);
		issue(blvs_pkg::CMD_SEARCH, 32'h8000_0000, 0);
		issue(blvs_pkg::CMD_SEARCH, 32'h0000_0005, 0);
		issue(blvs_pkg::CMD_DELETE, 32'h8000_0000, 1);
		issue(blvs_pkg::CMD_POP_FRONT, 32'h0, 0);
		issue(blvs_pkg::CMD_POP_BACK, 32'h0, 0);
		issue(blvs_pkg::CMD_POP_BACK, 32'h0, 0);

		// Fill with one value so that a search returns a match at every position.
		for (int i = 0; i < DEPTH; i++)
			issue(i[0] ? blvs_pkg::CMD_PUSH_FRONT : blvs_pkg::CMD_PUSH_BACK, 32'h5A5A_A5A5, 0);
		issue(blvs_pkg::CMD_PUSH_FRONT, 32'h1, 0);
		issue(blvs_pkg::CMD_PUSH_BACK, 32'h1, 3);
		issue(blvs_pkg::CMD_SEARCH, 32'h5A5A_A5A5, 0);
		issue(blvs_pkg::CMD_DELETE, 32'h5A5A_A5A5, 0);

		for (int k = 0; k < 134; k++) begin
			gap = ((k % 60) >= 45) ? 0 : pick_gap();
			r = $urandom_range(0, 99);
			if (r < 30)
				cmd = blvs_pkg::CMD_PUSH_BACK;
			else if (r < 50)
				cmd = blvs_pkg::CMD_PUSH_FRONT;
			else if (r < 60)
				cmd = blvs_pkg::CMD_POP_BACK;
			else if (r < 68)
				cmd = blvs_pkg::CMD_POP_FRONT;
			else if (r < 85)
				cmd = blvs_pkg::CMD_SEARCH;
			else if (r < 95)
				cmd = blvs_pkg::CMD_DELETE;
			else
				cmd = 3'($urandom_range(6, 7));
			issue(cmd, pick_value(), gap);
		end

		@(negedge clk);
		start <= 1'b0;
		spins = 0;
		while (tracker.awaited.size() != 0 && spins < 1000) begin
			@(posedge clk);
			spins++;
		end
		repeat (DEPTH + 4) @(posedge clk);
		if (tracker.awaited.size() != 0) begin
			$error("%0d expected results never arrived", tracker.awaited.size());
			tracker.failures++;
		end

		$display("Sent %0d requests and checked %0d results; peak occupancy %0d.",
			tracker.requests, tracker.checked, tracker.peak);
		$display("Searches with several matches: %0d; pushes refused on a full list: %0d.",
			tracker.multi_hit_searches, tracker.refused_pushes);
		if (tracker.failures == 0)
			$display("bounded_list_with_value_search: match");
		else
			$display("bounded_list_with_value_search: mismatch");
		$finish;
	end

endmodule
